### rtl/core/chkt_pkg.sv
// Shared types and codes for the chained hash key table.
package chkt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_MISS = 2'd2,
    STS_FULL = 2'd3
  } sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_BKT_RD,
    ST_BKT_WT,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_INS_RD,
    ST_INS_W1,
    ST_INS_W2,
    ST_RM_W1,
    ST_RM_W2,
    ST_RESP
  } state_t;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SHIFT_W = 4;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd8;
  localparam logic [ADDR_W-1:0] REG_SHIFT = 3'd0;

  typedef struct packed {
    logic load_req;
    logic load_idx;
    logic mod_step;
    logic bkt_rd;
    logic load_head;
    logic ent_rd;
    logic advance;
    logic free_rd;
    logic ins_w1;
    logic ins_w2;
    logic rm_w1;
    logic rm_w2;
    logic clr_step;
    logic out_load;
    sts_t code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       free_nil;
    logic       idx_big;
    logic       mod_last;
    logic       cur_nil;
    logic       key_match;
    logic       tail_nil;
    logic       p_nil;
    logic       clr_last;
    logic       out_busy;
  } stat_t;

endpackage

### rtl/core/chkt_ctrl.sv
// Request sequencer for the chained hash key table.
module chkt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  chkt_pkg::stat_t st,
  output chkt_pkg::cmd_t cmd,
  output logic           in_stall
);
  import chkt_pkg::*;

  state_t state_r, state_nxt;
  sts_t   code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      code_r  <= STS_MISS;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.load_idx = 1'b1;
        if (st.act == ACT_INSERT && st.free_nil) begin
          code_nxt  = STS_FULL;
          state_nxt = ST_RESP;
        end else if (st.act != ACT_INSERT && st.act != ACT_LOOKUP &&
                     st.act != ACT_REMOVE) begin
          code_nxt  = STS_MISS;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!st.idx_big) begin
          state_nxt = ST_BKT_RD;
        end else begin
          cmd.mod_step = 1'b1;
          if (st.mod_last) state_nxt = ST_BKT_RD;
        end
      end
      ST_BKT_RD: begin
        cmd.bkt_rd = 1'b1;
        state_nxt  = ST_BKT_WT;
      end
      ST_BKT_WT: begin
        cmd.load_head = 1'b1;
        state_nxt     = ST_KEY_RD;
      end
      ST_KEY_RD: begin
        if (st.cur_nil) begin
          if (st.act == ACT_INSERT) begin
            state_nxt = ST_INS_RD;
          end else begin
            code_nxt  = STS_MISS;
            state_nxt = ST_RESP;
          end
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt  = ST_KEY_CMP;
        end
      end
      ST_KEY_CMP: begin
        if (st.key_match) begin
          if (st.act == ACT_INSERT) begin
            code_nxt  = STS_DUP;
            state_nxt = ST_RESP;
          end else if (st.act == ACT_LOOKUP) begin
            code_nxt  = STS_OK;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_RM_W1;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_KEY_RD;
        end
      end
      ST_INS_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = ST_INS_W1;
      end
      ST_INS_W1: begin
        cmd.ins_w1 = 1'b1;
        code_nxt   = STS_OK;
        state_nxt  = st.tail_nil ? ST_RESP : ST_INS_W2;
      end
      ST_INS_W2: begin
        cmd.ins_w2 = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RM_W1: begin
        cmd.rm_w1 = 1'b1;
        code_nxt  = STS_OK;
        state_nxt = st.p_nil ? ST_RESP : ST_RM_W2;
      end
      ST_RM_W2: begin
        cmd.rm_w2 = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/chkt_dp.sv
// Datapath of the chained hash key table: stores, hash, chain links and result word.
module chkt_dp #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  chkt_pkg::cmd_t                   cmd,
  output chkt_pkg::stat_t                  st,
  input  logic [1:0]                       in_action,
  input  logic [chkt_pkg::KEY_W-1:0]       in_key_low,
  input  logic [chkt_pkg::KEY_W-1:0]       in_key_high,
  input  logic [chkt_pkg::VAL_W-1:0]       in_value_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [chkt_pkg::VAL_W-1:0]       out_value_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [chkt_pkg::ADDR_W-1:0]      paddr,
  input  logic [chkt_pkg::DATA_W-1:0]      pwdata,
  output logic [chkt_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import chkt_pkg::*;

  localparam int EW   = $clog2(ENTRIES + 1);
  localparam int IW   = $clog2(ENTRIES);
  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NMAX = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW   = $clog2(NMAX);
  localparam int KVW  = 2 * KEY_W + VAL_W;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);

  logic [2*EW-1:0] bkt_mem [BUCKETS];
  logic [EW-1:0]   nxt_mem [ENTRIES];
  logic [EW-1:0]   prv_mem [ENTRIES];
  logic [KVW-1:0]  kv_mem  [ENTRIES];

  logic [SHIFT_W-1:0] shift_r;
  logic [EW-1:0]      free_r, free_nxt;
  logic [CW-1:0]      clr_cnt_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [VAL_W-1:0]   out_value_r;

  logic [1:0]        act_r;
  logic [KEY_W-1:0]  klo_r, khi_r;
  logic [VAL_W-1:0]  val_r;
  logic [IDX_W-1:0]  idx_r;
  logic [STEP_W-1:0] k_r;
  logic [EW-1:0]     cur_r, head_r, tail_r;
  logic [2*EW-1:0]   bkt_rd_r;
  logic [EW-1:0]     nxt_rd_r, prv_rd_r;
  logic [KVW-1:0]    kv_rd_r;

  logic [31:0]       hash, mask, mod_cmp;
  logic [IDX_W-1:0]  idx_nxt;
  logic              bkt_we, nxt_we, prv_we, kv_we, ent_re;
  logic [BW-1:0]     bkt_wa;
  logic [2*EW-1:0]   bkt_wd;
  logic [IW-1:0]     nxt_wa, prv_wa, ent_ra;
  logic [EW-1:0]     nxt_wd, prv_wd, new_head, new_tail;
  logic              cfg_we;

  assign hash = ~(klo_r[31:0] ^ klo_r[63:32] ^ khi_r[31:0] ^ khi_r[63:32]);
  assign mask = (32'd1 << shift_r) - 32'd1;
  assign mod_cmp = 32'(BUCKETS) << k_r;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_idx) begin
      idx_nxt = hash[IDX_W-1:0] & mask[IDX_W-1:0];
    end else if (cmd.mod_step && 32'(idx_r) >= mod_cmp) begin
      idx_nxt = idx_r - mod_cmp[IDX_W-1:0];
    end
  end

  assign new_head = (prv_rd_r == NIL) ? nxt_rd_r : head_r;
  assign new_tail = (nxt_rd_r == NIL) ? prv_rd_r : tail_r;

  always_comb begin
    bkt_we   = 1'b0;
    bkt_wa   = idx_r[BW-1:0];
    bkt_wd   = {NIL, NIL};
    nxt_we   = 1'b0;
    nxt_wa   = cur_r[IW-1:0];
    nxt_wd   = NIL;
    prv_we   = 1'b0;
    prv_wa   = free_r[IW-1:0];
    prv_wd   = tail_r;
    kv_we    = 1'b0;
    free_nxt = free_r;
    ent_re   = cmd.ent_rd | cmd.free_rd;
    ent_ra   = cmd.free_rd ? free_r[IW-1:0] : cur_r[IW-1:0];
    if (cmd.clr_step) begin
      bkt_we = 32'(clr_cnt_r) < 32'(BUCKETS);
      bkt_wa = clr_cnt_r[BW-1:0];
      nxt_we = 32'(clr_cnt_r) < 32'(ENTRIES);
      nxt_wa = clr_cnt_r[IW-1:0];
      nxt_wd = EW'(clr_cnt_r) + EW'(1);
    end else if (cmd.ins_w1) begin
      bkt_we   = 1'b1;
      bkt_wd   = {((tail_r == NIL) ? free_r : head_r), free_r};
      nxt_we   = 1'b1;
      nxt_wa   = free_r[IW-1:0];
      nxt_wd   = NIL;
      prv_we   = 1'b1;
      kv_we    = 1'b1;
      free_nxt = nxt_rd_r;
    end else if (cmd.ins_w2) begin
      nxt_we = 1'b1;
      nxt_wa = tail_r[IW-1:0];
      nxt_wd = cur_r;
    end else if (cmd.rm_w1) begin
      bkt_we   = 1'b1;
      bkt_wd   = {new_head, new_tail};
      nxt_we   = 1'b1;
      nxt_wa   = cur_r[IW-1:0];
      nxt_wd   = free_r;
      prv_we   = nxt_rd_r != NIL;
      prv_wa   = nxt_rd_r[IW-1:0];
      prv_wd   = prv_rd_r;
      free_nxt = cur_r;
    end else if (cmd.rm_w2) begin
      nxt_we = 1'b1;
      nxt_wa = prv_rd_r[IW-1:0];
      nxt_wd = nxt_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (kv_we)  kv_mem[free_r[IW-1:0]] <= {klo_r, khi_r, val_r};
    if (cmd.bkt_rd) bkt_rd_r <= bkt_mem[idx_r[BW-1:0]];
    if (ent_re) begin
      nxt_rd_r <= nxt_mem[ent_ra];
      prv_rd_r <= prv_mem[ent_ra];
      kv_rd_r  <= kv_mem[ent_ra];
    end
  end

  assign cfg_we = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_SHIFT[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SHIFT_RST;
      free_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) shift_r <= pwdata[SHIFT_W-1:0];
      free_r <= free_nxt;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r <= in_action;
      klo_r <= in_key_low;
      khi_r <= in_key_high;
      val_r <= in_value_in;
    end
    idx_r <= idx_nxt;
    if (cmd.load_idx) begin
      k_r <= STEP_W'(IDX_W - 1);
    end else if (cmd.mod_step) begin
      k_r <= k_r - STEP_W'(1);
    end
    if (cmd.load_head) begin
      head_r <= bkt_rd_r[2*EW-1:EW];
      tail_r <= bkt_rd_r[EW-1:0];
      cur_r  <= bkt_rd_r[2*EW-1:EW];
    end else if (cmd.advance) begin
      cur_r <= nxt_rd_r;
    end else if (cmd.ins_w1) begin
      cur_r <= free_r;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.code;
      out_value_r  <= (cmd.code == STS_OK && act_r == ACT_LOOKUP) ?
                      kv_rd_r[VAL_W-1:0] : '0;
    end
  end

  always_comb begin
    st.act       = act_r;
    st.free_nil  = free_r == NIL;
    st.idx_big   = 32'(idx_r) >= 32'(BUCKETS);
    st.mod_last  = k_r == '0;
    st.cur_nil   = cur_r == NIL;
    st.key_match = (kv_rd_r[KVW-1:KEY_W+VAL_W] == klo_r) &&
                   (kv_rd_r[KEY_W+VAL_W-1:VAL_W] == khi_r);
    st.tail_nil  = tail_r == NIL;
    st.p_nil     = prv_rd_r == NIL;
    st.clr_last  = 32'(clr_cnt_r) == 32'(NMAX - 1);
    st.out_busy  = out_valid_r & out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign pready        = 1'b1;
  assign prdata        = (paddr[ADDR_W-1:2] == REG_SHIFT[ADDR_W-1:2]) ?
                         DATA_W'(shift_r) : '0;

endmodule

### rtl/core/chained_hash_key_table_unit.sv
// Top level of the chained hash key table.
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall  | action, key_low, key_high, value_in
//  out_    | output    | out_valid / out_stall| status, value_out
//  APB     | input     | psel/penable/pready  | bucket_shift at byte address 0
// A request goes from IDLE through HASH, MOD, BKT_RD and BKT_WT into the chain walk,
// which reads and compares one entry at a time; MOD reduces a bucket index at or
// above BUCKETS by subtraction. An insert reads the free entry and writes one or two
// links, a remove one or two. A full-pool insert or unused action skips to RESP.
// The chain walk through the single-port entry stores sets the rate.
// After reset a clearing pass over all buckets and entries runs; in_stall holds.
// A stalled result waits in the output register; the next word may still be taken.
module chained_hash_key_table_unit #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [chkt_pkg::KEY_W-1:0]  in_key_low,
  input  logic [chkt_pkg::KEY_W-1:0]  in_key_high,
  input  logic [chkt_pkg::VAL_W-1:0]  in_value_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [chkt_pkg::VAL_W-1:0]  out_value_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chkt_pkg::ADDR_W-1:0] paddr,
  input  logic [chkt_pkg::DATA_W-1:0] pwdata,
  output logic [chkt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import chkt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  chkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  chkt_dp #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_action     (in_action),
    .in_key_low    (in_key_low),
    .in_key_high   (in_key_high),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

endmodule
